/* rtl/core/lci_pkg.sv */
// Package: shared constants, types and state codes of the level crossing interpolator.
package lci_pkg;

   localparam int MAX_FRAME = 65536;
   localparam int IDX_LIMIT = (MAX_FRAME < 65536) ? MAX_FRAME : 65536;

   localparam int SMP_W  = 16;
   localparam int ABS_W  = 32;
   localparam int IDX_W  = 16;
   localparam int LOC_W  = 40;
   localparam int CNT_W  = 17;
   localparam int FRAC_W = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START   = 2'd2;

   localparam int DEN_W  = SMP_W + 1;
   localparam int P1_W   = ABS_W + DEN_W;
   localparam int DX_W   = ABS_W + 1;
   localparam int NUM_W  = P1_W + 1;
   localparam int DVD_W  = NUM_W - 1 + FRAC_W;
   localparam int DVS_W  = SMP_W;
   localparam int STEP_W = $clog2(DVD_W);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic                    found;
      logic [IDX_W-1:0]        index;
      logic signed [SMP_W-1:0] smp;
      logic signed [ABS_W-1:0] absc;
      logic signed [SMP_W-1:0] prev_smp;
      logic signed [ABS_W-1:0] prev_absc;
      logic signed [SMP_W-1:0] level;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_SUM,
      BK_DIV,
      BK_FIX
   } back_state_type;

endpackage

/* rtl/core/lci_if.sv */
// Interfaces: sample, result and register-write channels.
interface lci_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [lci_pkg::SMP_W-1:0]       sample;
   logic signed [lci_pkg::ABS_W-1:0]       abscissa;
   logic                                   last_sample;

   modport source (output valid, sample, abscissa, last_sample, input ready);
   modport sink   (input valid, sample, abscissa, last_sample, output ready);
endinterface

interface lci_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   found;
   logic [lci_pkg::IDX_W-1:0]              crossing_index;
   logic signed [lci_pkg::LOC_W-1:0]       location;

   modport source (output valid, found, crossing_index, location, input ready);
   modport sink   (input valid, found, crossing_index, location, output ready);
endinterface

interface lci_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [lci_pkg::CSR_IDX_W-1:0]          index;
   logic [lci_pkg::CSR_DATA_W-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/lci_front.sv */
// Front end: register file, per-frame scan state and crossing classification.
module lci_front (
   input  logic                clock,
   input  logic                reset,
   lci_req_if.sink             req_ch,
   lci_csr_if.sink             csr_ch,
   input  logic                q_full,
   output logic                q_push,
   output lci_pkg::job_type    q_job
);

   logic signed [lci_pkg::SMP_W-1:0] level_ff;
   logic                             falling_ff;
   logic [lci_pkg::IDX_W-1:0]        start_ff;

   logic signed [lci_pkg::SMP_W-1:0] prev_smp_ff, prev_smp_in;
   logic signed [lci_pkg::ABS_W-1:0] prev_absc_ff, prev_absc_in;
   logic [lci_pkg::CNT_W-1:0]        count_ff, count_in;
   logic                             armed_ff, armed_in;
   logic                             done_ff, done_in;

   logic                             accept;
   logic                             examine;
   logic                             at_or_wrong;
   logic                             hit;
   logic                             below_limit;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         falling_ff <= 1'b0;
         start_ff   <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            lci_pkg::CSR_LEVEL:   level_ff   <= csr_ch.data;
            lci_pkg::CSR_FALLING: falling_ff <= csr_ch.data[0];
            lci_pkg::CSR_START:   start_ff   <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      below_limit = count_ff < lci_pkg::CNT_W'(lci_pkg::IDX_LIMIT);
      examine     = !done_ff && below_limit && (count_ff >= {1'b0, start_ff});
      // at the level or on the side it must leave
      at_or_wrong = falling_ff ? (req_ch.sample >= level_ff) : (req_ch.sample <= level_ff);
      hit         = examine && !at_or_wrong && armed_ff;

      prev_smp_in  = prev_smp_ff;
      prev_absc_in = prev_absc_ff;
      count_in     = count_ff;
      armed_in     = armed_ff;
      done_in      = done_ff;
      q_push       = 1'b0;

      if (accept) begin
         prev_smp_in  = req_ch.sample;
         prev_absc_in = req_ch.abscissa;
         if (examine && at_or_wrong) armed_in = 1'b1;
         if (hit) done_in = 1'b1;
         if (below_limit) count_in = count_ff + 1'b1;
         q_push = hit || (req_ch.last_sample && !done_ff);
         if (req_ch.last_sample) begin
            count_in = '0;
            armed_in = 1'b0;
            done_in  = 1'b0;
         end
      end

      q_job.found     = hit;
      q_job.index     = count_ff[lci_pkg::IDX_W-1:0];
      q_job.smp       = req_ch.sample;
      q_job.absc      = req_ch.abscissa;
      q_job.prev_smp  = prev_smp_ff;
      q_job.prev_absc = prev_absc_ff;
      q_job.level     = level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_smp_ff  <= '0;
         prev_absc_ff <= '0;
         count_ff     <= '0;
         armed_ff     <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         prev_smp_ff  <= prev_smp_in;
         prev_absc_ff <= prev_absc_in;
         count_ff     <= count_in;
         armed_ff     <= armed_in;
         done_ff      <= done_in;
      end
   end

endmodule

/* rtl/core/lci_queue.sv */
// Short job queue between the front end and the interpolation back end.
module lci_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lci_pkg::job_type    push_job,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output lci_pkg::job_type    pop_job
);

   lci_pkg::job_type            slot_ff [lci_pkg::QDEPTH];
   logic [lci_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [lci_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [lci_pkg::QCNT_W-1:0]  cnt_ff, cnt_in;
   logic                        do_push, do_pop;

   always_comb begin
      full      = cnt_ff == lci_pkg::QCNT_W'(lci_pkg::QDEPTH);
      pop_valid = cnt_ff != '0;
      pop_job   = slot_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && pop_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* rtl/core/lci_back.sv */
// Back end: interpolation multiply, serial divide and result register.
module lci_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  lci_pkg::job_type    q_job,
   output logic                q_pop,
   lci_rsp_if.source           rsp_ch
);

   lci_pkg::back_state_type          state_ff, state_in;
   lci_pkg::job_type                 job_ff, job_in;

   logic signed [lci_pkg::P1_W-1:0]  p1_ff, p1_in;
   logic signed [lci_pkg::NUM_W-1:0] p2_ff, p2_in;
   logic                             den_neg_ff, den_neg_in;
   logic [lci_pkg::DVS_W-1:0]        dvs_ff, dvs_in;
   logic                             den_zero_ff, den_zero_in;
   logic                             neg_ff, neg_in;
   logic [lci_pkg::DVD_W-1:0]        quo_ff, quo_in;
   logic [lci_pkg::DVS_W-1:0]        rem_ff, rem_in;
   logic [lci_pkg::STEP_W-1:0]       step_ff, step_in;

   logic                             out_valid_ff, out_valid_in;
   logic                             out_found_ff, out_found_in;
   logic [lci_pkg::IDX_W-1:0]        out_index_ff, out_index_in;
   logic signed [lci_pkg::LOC_W-1:0] out_loc_ff, out_loc_in;

   logic signed [lci_pkg::DEN_W-1:0] den;
   logic signed [lci_pkg::DX_W-1:0]  dx;
   logic signed [lci_pkg::DEN_W-1:0] dl;
   logic signed [lci_pkg::NUM_W-1:0] num;
   logic [lci_pkg::NUM_W-2:0]        num_mag;
   logic [lci_pkg::DVS_W:0]          trial;
   logic [lci_pkg::DVD_W-1:0]        quo_signed;
   logic                             out_free;

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.found          = out_found_ff;
   assign rsp_ch.crossing_index = out_index_ff;
   assign rsp_ch.location       = out_loc_ff;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      den_neg_in   = den_neg_ff;
      dvs_in       = dvs_ff;
      den_zero_in  = den_zero_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      out_found_in = out_found_ff;
      out_index_in = out_index_ff;
      out_loc_in   = out_loc_ff;
      q_pop        = 1'b0;

      out_free     = !out_valid_ff || rsp_ch.ready;
      out_valid_in = out_valid_ff && !rsp_ch.ready;

      den     = lci_pkg::DEN_W'(job_ff.smp) - lci_pkg::DEN_W'(job_ff.prev_smp);
      dx      = lci_pkg::DX_W'(job_ff.absc) - lci_pkg::DX_W'(job_ff.prev_absc);
      dl      = lci_pkg::DEN_W'(job_ff.level) - lci_pkg::DEN_W'(job_ff.prev_smp);
      num     = lci_pkg::NUM_W'(p1_ff) + p2_ff;
      num_mag = (lci_pkg::NUM_W-1)'(num[lci_pkg::NUM_W-1] ? -num : num);
      trial   = {rem_ff, quo_ff[lci_pkg::DVD_W-1]};
      quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

      case (state_ff)
         lci_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               job_in   = q_job;
               state_in = q_job.found ? lci_pkg::BK_MUL : lci_pkg::BK_FIX;
            end
         end
         lci_pkg::BK_MUL: begin
            p1_in      = lci_pkg::P1_W'(job_ff.prev_absc) * lci_pkg::P1_W'(den);
            p2_in      = lci_pkg::NUM_W'(dx) * lci_pkg::NUM_W'(dl);
            den_neg_in = den[lci_pkg::DEN_W-1];
            dvs_in     = lci_pkg::DVS_W'(den[lci_pkg::DEN_W-1] ? -den : den);
            den_zero_in = den == '0;
            state_in   = lci_pkg::BK_SUM;
         end
         lci_pkg::BK_SUM: begin
            neg_in   = num[lci_pkg::NUM_W-1] ^ den_neg_ff;
            quo_in   = {num_mag, {lci_pkg::FRAC_W{1'b0}}};
            rem_in   = '0;
            step_in  = '0;
            state_in = den_zero_ff ? lci_pkg::BK_FIX : lci_pkg::BK_DIV;
         end
         lci_pkg::BK_DIV: begin
            // one quotient bit per cycle, restoring
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in = lci_pkg::DVS_W'(trial - {1'b0, dvs_ff});
               quo_in = {quo_ff[lci_pkg::DVD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[lci_pkg::DVS_W-1:0];
               quo_in = {quo_ff[lci_pkg::DVD_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == lci_pkg::STEP_W'(lci_pkg::DVD_W - 1)) state_in = lci_pkg::BK_FIX;
         end
         lci_pkg::BK_FIX: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_found_in = job_ff.found;
               if (!job_ff.found) begin
                  out_index_in = '0;
                  out_loc_in   = '0;
               end else begin
                  out_index_in = job_ff.index;
                  if (den_zero_ff) out_loc_in = {job_ff.absc, {lci_pkg::FRAC_W{1'b0}}};
                  else             out_loc_in = quo_signed[lci_pkg::LOC_W-1:0];
               end
               state_in = lci_pkg::BK_IDLE;
            end
         end
         default: state_in = lci_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lci_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      den_neg_ff   <= den_neg_in;
      dvs_ff       <= dvs_in;
      den_zero_ff  <= den_zero_in;
      neg_ff       <= neg_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      out_found_ff <= out_found_in;
      out_index_ff <= out_index_in;
      out_loc_ff   <= out_loc_in;
   end

endmodule

/* rtl/core/level_crossing_interpolator.sv */
// Top level: level crossing search with linearly interpolated location.
//
//   channel  dir  beat carries
//   req_ch   in   sample, abscissa, last_sample
//   rsp_ch   out  found, crossing_index, location
//   csr_ch   in   index (0 level, 1 falling, 2 start_index), data
//
// Samples are taken one per cycle while the four-entry job queue has room.
// A found crossing passes the back end states load, multiply, sum, 57 divide
// steps and result, the divider being bit-serial; a not-found result goes from
// load straight to result. Register writes complete in the cycle they are offered.
// Reset is synchronous and clears scan state, queue and result valid at once.
// A stalled result holds its register; the front end keeps taking samples
// until the queue fills.
module level_crossing_interpolator (
   input  logic        clock,
   input  logic        reset,
   lci_req_if.sink     req_ch,
   lci_rsp_if.source   rsp_ch,
   lci_csr_if.sink     csr_ch
);

   logic               q_push, q_full, q_pop, q_valid;
   lci_pkg::job_type   push_job, pop_job;

   lci_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (push_job)
   );

   lci_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (pop_job)
   );

   lci_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (pop_job),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

/* rtl/core/lci_checker.sv */
// Checker on the result port of the level crossing interpolator, with its bind.
module lci_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_found,
   input logic [lci_pkg::IDX_W-1:0]         rsp_index,
   input logic signed [lci_pkg::LOC_W-1:0]  rsp_location
);

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_found) && $stable(rsp_index) && $stable(rsp_location))
      else $error("result payload changed while stalled");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_index == '0 && rsp_location == '0)
      else $error("not-found result carries index or location");

   a_no_result_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind level_crossing_interpolator lci_checker u_lci_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_found    (rsp_ch.found),
   .rsp_index    (rsp_ch.crossing_index),
   .rsp_location (rsp_ch.location)
);
